>>> rtl/core/sample_player_with_gain_assert.svh
// Assertion macros used by the checker file.
`ifndef SAMPLE_PLAYER_WITH_GAIN_ASSERT_SVH
`define SAMPLE_PLAYER_WITH_GAIN_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/core/spg_pkg.sv
package spg_pkg;

  localparam int unsigned IDX_W = 16;
  localparam int unsigned LEN_W = 17;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_START  = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STARTED = 3'd1,
    EV_PAUSED  = 3'd2,
    EV_RESUMED = 3'd3,
    EV_INDEX   = 3'd4
  } event_e;

  // Config register indexes
  localparam logic [1:0] CFG_GAIN     = 2'd0;
  localparam logic [1:0] CFG_MIDPOINT = 2'd1;
  localparam logic [1:0] CFG_LENGTH   = 2'd2;

  localparam logic [3:0]       GAIN_RST   = 4'd2;
  localparam logic [7:0]       MID_RST    = 8'd121;
  localparam logic [LEN_W-1:0] LENGTH_RST = 17'h10000;
  localparam logic [7:0]       LEVEL_MAX  = 8'd255;

  // Per-item control word handed from the command stage to the level stage
  typedef struct packed {
    logic             is_load;
    logic             play;
    event_e           kind;
    logic [IDX_W-1:0] index;
  } ctrl_t;

endpackage

>>> rtl/core/spg_ctrl.sv
module spg_ctrl
  import spg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             req_type_i,
  input  logic [1:0]       command_i,
  input  logic [LEN_W-1:0] play_length_i,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_index_o,
  output ctrl_t            item_o
);

  logic             started_q, started_d;
  logic             paused_q, paused_d;
  logic [IDX_W-1:0] index_q, index_d;
  logic [LEN_W-1:0] next_idx;
  logic             play;
  cmd_e             cmd;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    started_d   = started_q;
    paused_d    = paused_q;
    item_o.kind = EV_NONE;
    item_o.index = '0;
    case (cmd)
      CMD_START: begin
        if (!started_q) begin
          started_d   = 1'b1;
          paused_d    = 1'b0;
          item_o.kind = EV_STARTED;
        end
      end
      CMD_TOGGLE: begin
        if (started_q) begin
          paused_d    = !paused_q;
          item_o.kind = paused_q ? EV_RESUMED : EV_PAUSED;
        end
      end
      CMD_REPORT: begin
        if (started_q) begin
          item_o.kind  = EV_INDEX;
          item_o.index = index_q;
        end
      end
      default: ;
    endcase
    if (req_type_i) begin
      started_d    = started_q;
      paused_d     = paused_q;
      item_o.kind  = EV_NONE;
      item_o.index = '0;
    end
    item_o.is_load = req_type_i;
    item_o.play    = !req_type_i && started_d && !paused_d;
  end

  assign play = item_o.play;

  // wrap at play_length; a length above 2^16 wraps through the index width
  assign next_idx = {1'b0, index_q} + LEN_W'(1);
  assign index_d  = (next_idx >= play_length_i) ? '0 : next_idx[IDX_W-1:0];

  assign rd_en_o    = accept_i && play;
  assign rd_index_o = index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      paused_q  <= 1'b0;
      index_q   <= '0;
    end else if (accept_i && !req_type_i) begin
      started_q <= started_d;
      paused_q  <= paused_d;
      if (play) begin
        index_q <= index_d;
      end
    end
  end

endmodule

>>> rtl/core/spg_store.sv
module spg_store #(
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]                      wr_data_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0] rd_addr_i,
  output logic [7:0]                      rd_data_o
);

  logic [7:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/core/spg_amp.sv
module spg_amp
  import spg_pkg::*;
(
  input  logic [7:0] sample_i,
  input  logic [7:0] midpoint_i,
  input  logic [3:0] gain_i,
  output logic [7:0] level_o
);

  logic signed [8:0]  dev;
  logic signed [13:0] prod;
  logic signed [14:0] sum;

  always_comb begin
    dev  = $signed({1'b0, sample_i}) - $signed({1'b0, midpoint_i});
    prod = dev * $signed({1'b0, gain_i});
    sum  = 15'(prod) + $signed({7'd0, midpoint_i});
    if (sum < 0) begin
      level_o = '0;
    end else if (sum > $signed({7'd0, LEVEL_MAX})) begin
      level_o = LEVEL_MAX;
    end else begin
      level_o = sum[7:0];
    end
  end

endmodule

>>> rtl/core/sample_player_with_gain.sv
// Order: the accepting edge does the store access and fills stage 1, then the level
// register takes the result. Throughput: one item per cycle unless the output stalls;
// each item makes at most one store access.
// Reset (rst_ni, async low): stopped, unpaused, index 0, level 121, gain 2,
// midpoint 121, play length 65536. Sample store is not cleared and holds
// garbage until loaded.
module sample_player_with_gain
  import spg_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [1:0]        command_i,
  input  logic [IDX_W-1:0]  load_address_i,
  input  logic [7:0]        load_sample_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        pwm_level_o,
  output logic [2:0]        event_kind_o,
  output logic [IDX_W-1:0]  event_index_o,
  // config writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [LEN_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  // config registers
  logic [3:0]       gain_q;
  logic [7:0]       mid_q;
  logic [LEN_W-1:0] len_q;

  // stage 1: item whose sample read is in flight
  logic             s1_valid_q;
  ctrl_t            s1_q;
  logic             s1_go;

  // output register
  logic             out_valid_q;
  logic [7:0]       pwm_q;
  event_e           kind_q;
  logic [IDX_W-1:0] idx_q;

  // last level shown, repeated by load items
  logic [7:0]       last_level_q;
  logic [7:0]       level_d;

  logic             in_accept;
  logic             rd_en;
  logic [IDX_W-1:0] rd_index;
  logic [7:0]       rd_data;
  logic [7:0]       amp_level;
  ctrl_t            item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      mid_q  <= MID_RST;
      len_q  <= LENGTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAIN:     gain_q <= cfg_data_i[3:0];
        CFG_MIDPOINT: mid_q  <= cfg_data_i[7:0];
        CFG_LENGTH:   len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1 advances whenever the output register is free or being drained;
  // input is taken whenever stage 1 is empty or advancing.
  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;

  // Command decode, play state and index; issues the store read.
  spg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .req_type_i    (req_type_i),
    .command_i     (command_i),
    .play_length_i (len_q),
    .rd_en_o       (rd_en),
    .rd_index_o    (rd_index),
    .item_o        (item)
  );

  // Load items write at accept; a later tick reads at its own accept, so
  // back-to-back load then play sees the new sample.
  spg_store #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && req_type_i),
    .wr_addr_i (AW'(load_address_i)),
    .wr_data_i (load_sample_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (AW'(rd_index)),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_go);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= item;
    end
  end

  // Gain about the midpoint, clamped to 0..255.
  spg_amp u_amp (
    .sample_i   (rd_data),
    .midpoint_i (mid_q),
    .gain_i     (gain_q),
    .level_o    (amp_level)
  );

  always_comb begin
    if (s1_q.is_load) begin
      level_d = last_level_q;
    end else if (s1_q.play) begin
      level_d = amp_level;
    end else begin
      level_d = mid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      last_level_q <= MID_RST;
    end else begin
      out_valid_q <= s1_go || (out_valid_q && !out_ready_i);
      if (s1_go) begin
        last_level_q <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      pwm_q  <= level_d;
      kind_q <= s1_q.kind;
      idx_q  <= s1_q.index;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pwm_level_o   = pwm_q;
  assign event_kind_o  = kind_q;
  assign event_index_o = idx_q;

endmodule

>>> rtl/core/sample_player_with_gain_chk.sv
`include "sample_player_with_gain_assert.svh"

module sample_player_with_gain_chk
  import spg_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [7:0]       pwm_level_o,
  input logic [2:0]       event_kind_o,
  input logic [IDX_W-1:0] event_index_o
);

  // every accepted item is followed by a valid result
  `SPG_ASSERT_IMP(a_result_follows, in_valid_i && in_ready_o, ##2 out_valid_o)

  // an empty output side never blocks the input
  `SPG_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o)

  // index field is zero unless this is an index report
  `SPG_ASSERT_IMP(a_index_only_on_report, out_valid_o && (event_kind_o != EV_INDEX),
                  event_index_o == '0)

  // stalled result holds
  `SPG_ASSERT_NXT(a_stall_holds, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(pwm_level_o) && $stable(event_kind_o))

endmodule

bind sample_player_with_gain sample_player_with_gain_chk u_chk (.*);
